### rtl/b2d_pkg.sv
// shared types and constants of the binary to decimal ascii converter
package b2d_pkg;

	localparam int unsigned VALUE_W   = 64;
	localparam int unsigned DIGITS    = 20;
	localparam int unsigned BCD_W     = 4;
	localparam int unsigned CHAR_W    = 6;
	localparam int unsigned BIT_CNT_W = $clog2(VALUE_W);
	localparam int unsigned DIG_CNT_W = $clog2(DIGITS + 1);

	localparam logic [CHAR_W-1:0]    ASCII_ZERO = 6'd48;
	localparam logic [BCD_W-1:0]     DABBLE_MIN = 4'd5;
	localparam logic [BCD_W-1:0]     DABBLE_ADD = 4'd3;
	localparam logic [BIT_CNT_W-1:0] BIT_LAST   = BIT_CNT_W'(VALUE_W - 1);
	localparam logic [DIG_CNT_W-1:0] DIG_TOTAL  = DIG_CNT_W'(DIGITS);

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_CLEAR,
		CMD_DABBLE,
		CMD_SHIFT
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

endpackage

### rtl/b2d_cell.sv
// one bcd digit cell: hold, clear, shift-and-add-3 step or digit shift toward the top
module b2d_cell
	import b2d_pkg::*;
(
	input  logic             clk,
	input  cell_cmd_t        cmd,
	input  logic             carry_in,
	output logic             carry_out,
	input  logic [BCD_W-1:0] digit_in,
	output logic [BCD_W-1:0] digit_out
);

	logic [BCD_W-1:0] digit_q;
	logic [BCD_W-1:0] adj;
	logic [BCD_W-1:0] digit_d;

	assign adj       = (digit_q >= DABBLE_MIN) ? digit_q + DABBLE_ADD : digit_q;
	assign carry_out = adj[BCD_W-1];
	assign digit_out = digit_q;

	always_comb begin
		case (cmd)
			CMD_HOLD:   digit_d = digit_q;
			CMD_CLEAR:  digit_d = '0;
			CMD_DABBLE: digit_d = {adj[BCD_W-2:0], carry_in};
			CMD_SHIFT:  digit_d = digit_in;
			default:    digit_d = digit_q;
		endcase
	end

	always_ff @(posedge clk) begin
		digit_q <= digit_d;
	end

endmodule

### rtl/binary_to_decimal_ascii.sv
// top level: 64-bit unsigned binary to decimal ascii digit stream
//
// channel | dir | fields
// s_*     | in  | tdata[63:0] value
// m_*     | out | tdata[5:0] digit_char, tdata[7:6] zero; tlast = last
//
// a value is accepted in the idle state, then takes one shift-and-add-3 step per
// value bit through the row of 20 digit cells, then 20 digit
// shifts out of the top cell, leading zeros skipped at one a cycle
// s_tready is high only while the converter is idle
// m_* is a registered stage; a stall on m_tready holds the digit shifts,
// not the leading zero skips; arst_n clears the control state and output valid
module binary_to_decimal_ascii
	import b2d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // value[63:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // digit_char[5:0], zero[7:6]
	output logic        m_tlast
);

	state_t                state_q, state_d;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;
	logic [DIG_CNT_W-1:0]  dig_cnt_q;
	logic                  started_q;
	logic [VALUE_W-1:0]    sh_q;
	logic                  m_tvalid_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;

	cell_cmd_t             cmd;
	logic                  in_fire;
	logic                  out_free;
	logic                  skip;
	logic                  step;
	logic                  load_out;
	logic                  emit_last;

	logic [DIGITS-1:0]     carry;
	logic [BCD_W-1:0]      digit [DIGITS];
	logic [BCD_W-1:0]      top_digit;

	assign top_digit = digit[DIGITS-1];
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign emit_last = (dig_cnt_q == DIG_CNT_W'(1));
	assign skip      = !started_q && (top_digit == '0) && !emit_last;

	genvar gi;
	generate
		for (gi = 0; gi < DIGITS; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				b2d_cell u_cell (
					.clk       (clk),
					.cmd       (cmd),
					.carry_in  (sh_q[VALUE_W-1]),
					.carry_out (carry[gi]),
					.digit_in  ('0),
					.digit_out (digit[gi])
				);
			end else begin : g_rest
				b2d_cell u_cell (
					.clk       (clk),
					.cmd       (cmd),
					.carry_in  (carry[gi-1]),
					.carry_out (carry[gi]),
					.digit_in  (digit[gi-1]),
					.digit_out (digit[gi])
				);
			end
		end
	endgenerate

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_CONV;
			ST_CONV: if (bit_cnt_q == '0) state_d = ST_EMIT;
			ST_EMIT: if (step && !skip && emit_last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the control
	always_comb begin
		s_tready = 1'b0;
		cmd      = CMD_HOLD;
		step     = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) cmd = CMD_CLEAR;
			end
			ST_CONV: cmd = CMD_DABBLE;
			ST_EMIT: begin
				step     = skip || out_free;
				load_out = step && !skip;
				if (step) cmd = CMD_SHIFT;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bit_cnt_q  <= '0;
			dig_cnt_q  <= '0;
			started_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				bit_cnt_q <= BIT_LAST;
			end else if (state_q == ST_CONV) begin
				bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
			end
			if (state_q == ST_CONV) begin
				dig_cnt_q <= DIG_TOTAL;
				started_q <= 1'b0;
			end else if (step) begin
				dig_cnt_q <= dig_cnt_q - DIG_CNT_W'(1);
				if (!skip) started_q <= 1'b1;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sh_q <= s_tdata;
		end else if (state_q == ST_CONV) begin
			sh_q <= {sh_q[VALUE_W-2:0], 1'b0};
		end
		if (load_out) begin
			char_q <= ASCII_ZERO | CHAR_W'(top_digit);
			last_q <= emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, char_q};
	assign m_tlast  = last_q;

`ifndef SYNTH
	a_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_CONV) && (bit_cnt_q == BIT_LAST))
		else $error("accepted value did not start a conversion");

	a_digit_is_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (top_digit <= 4'd9))
		else $error("top cell holds a non-decimal digit");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && emit_last) |=> (state_q == ST_IDLE) && m_tvalid && m_tlast)
		else $error("final digit did not end the run");

	a_no_zero_lead: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && !started_q && !emit_last) |-> (top_digit != '0))
		else $error("leading zero emitted");
`endif

endmodule
